@@ design/gauss_seidel_laplace_solver_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Gauss-Seidel Laplace solver: assertion macros
// Concurrent check macros shared by the files that assert. They collapse to
// nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef GAUSS_SEIDEL_LAPLACE_SOLVER_UNIT_DEFINES_SVH
`define GAUSS_SEIDEL_LAPLACE_SOLVER_UNIT_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, quiet while reset is asserted.
`define GSLPS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("gslps: same-cycle check failed");
// Next-cycle implication, quiet while reset is asserted.
`define GSLPS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("gslps: next-cycle check failed");
`else
`define GSLPS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define GSLPS_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ design/gslps_pkg.sv @@
// ----------------------------------------------------------------------------
// gslps_pkg
// Types, codes and fixed widths of the Gauss-Seidel Laplace solver.
// ----------------------------------------------------------------------------
package gslps_pkg;

  localparam int CELL_W     = 32;  // Q16.16 cell
  localparam int SUM_W      = 34;  // four-neighbor sum, never overflows
  localparam int CHG_W      = 33;  // absolute change of one cell
  localparam int CNT_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Operation codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_SOLVE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SWEEPS = 2'd3;

  // Register reset values
  localparam logic [7:0]       ROWS_RST       = 8'd128;
  localparam logic [7:0]       COLS_RST       = 8'd128;
  localparam logic [CNT_W-1:0] TOLERANCE_RST  = 16'd0;
  localparam logic [CNT_W-1:0] MAX_SWEEPS_RST = 16'd10000;

  // Fetch phases of one cell: read address issued / data landing
  localparam logic [2:0] PH_N   = 3'd0;
  localparam logic [2:0] PH_S   = 3'd1;
  localparam logic [2:0] PH_E   = 3'd2;
  localparam logic [2:0] PH_W   = 3'd3;
  localparam logic [2:0] PH_C   = 3'd4;
  localparam logic [2:0] PH_OLD = 3'd5;

  typedef struct packed {
    logic [1:0]        operation;
    logic [6:0]        row;
    logic [6:0]        col;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [15:0]        sweeps_done;
    logic               converged;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RDATA,
    S_SWEEP,
    S_FETCH,
    S_ROUND,
    S_DIFF,
    S_ABS,
    S_END
  } state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

endpackage

@@ design/gslps_ram.sv @@
// ----------------------------------------------------------------------------
// gslps_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module gslps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ design/gslps_alu.sv @@
// ----------------------------------------------------------------------------
// gslps_alu
// Shared 34-bit add/subtract unit of the sweep datapath.
// ----------------------------------------------------------------------------
module gslps_alu
  import gslps_pkg::*;
(
  input  alu_op_t                 op,
  input  logic signed [SUM_W-1:0] a,
  input  logic signed [SUM_W-1:0] b,
  output logic signed [SUM_W-1:0] y
);

  always_comb begin
    unique case (op)
      ALU_ADD: y = a + b;
      ALU_SUB: y = a - b;
      default: y = a + b;
    endcase
  end

endmodule

@@ design/gauss_seidel_laplace_solver_unit.sv @@
// ----------------------------------------------------------------------------
// gauss_seidel_laplace_solver_unit
// Grid store with write, read and in-place Gauss-Seidel Laplace solve.
// ----------------------------------------------------------------------------
// Timing and use: a command beat is taken when start is high and busy is low.
// Every command returns exactly one result beat on out_data, marked by
// out_strobe for one cycle; the receiver cannot stall it, so sample it then.
// A write (or the unused code) leaves busy low, so the next command may
// follow directly. A read passes through S_RDATA for the registered RAM read.
// A solve repeats sweeps over the interior cells of the grid in use, R and C
// being its rows and columns; with fewer than three of either a sweep has no
// interior cell. The single RAM port gives each interior cell fetch phases
// for five reads (N, S, E, W, center, the last landing one phase after its
// address), then round, write-back and absolute change, all through one
// shared adder. The grid store is not cleared at reset; write every cell in
// use before reading it or solving over it. Configuration writes are always
// taken (cfg_ready is high); issue them only while idle.
// ----------------------------------------------------------------------------
`include "gauss_seidel_laplace_solver_unit_defines.svh"

module gauss_seidel_laplace_solver_unit
  import gslps_pkg::*;
#(
  parameter int MAX_DIM = 128
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Command channel
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_data,
  // Result channel
  output logic                  out_strobe,
  output out_item_t             out_data,
  // Configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Index width of one grid coordinate, width for dimension math, store depth
  localparam int IW    = $clog2(MAX_DIM);
  localparam int DW    = (IW + 2 > 9) ? IW + 2 : 9;
  localparam int RX    = (IW > 7) ? IW : 7;
  localparam int AW    = 2 * IW;
  localparam int DEPTH = 1 << AW;
  localparam logic [DW-1:0] MAXD = DW'(MAX_DIM);

  // --------------------------------------------------------------------------
  // Declarations
  // --------------------------------------------------------------------------
  state_t state_r, state_nxt;

  logic [7:0]       grid_rows_r, grid_cols_r;
  logic [CNT_W-1:0] tolerance_r, max_sweeps_r;

  logic [IW-1:0]          i_r, i_nxt, j_r, j_nxt;
  logic [2:0]             phase_r, phase_nxt;
  logic signed [SUM_W-1:0] acc_r, acc_nxt;
  logic signed [CELL_W-1:0] old_r, old_nxt;
  logic [CHG_W-1:0]       largest_r, largest_nxt;
  logic [CNT_W-1:0]       sweep_cnt_r, sweep_cnt_nxt;
  logic                   rd_inside_r, rd_inside_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_r, out_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  alu_op_t                 alu_op;
  logic signed [SUM_W-1:0] alu_a, alu_b, alu_y;

  logic                     accept;
  logic                     in_inside;
  logic [RX-1:0]            in_row_x, in_col_x;
  logic [AW-1:0]            in_addr;
  logic [DW-1:0]            nr, nc;
  logic                     has_interior, j_more, i_more, keep_going;
  logic [CNT_W-1:0]         cnt_inc;
  logic signed [SUM_W-1:0]  rd_ext;
  logic signed [CELL_W-1:0] nv;
  logic [CHG_W-1:0]         abs_chg;

  function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] r,
                                              input logic [IW-1:0] c);
    return {r, c};
  endfunction

  // --------------------------------------------------------------------------
  // Handshakes and derived values
  // --------------------------------------------------------------------------
  assign busy       = (state_r != S_IDLE);
  assign accept     = start && !busy;
  assign cfg_ready  = 1'b1;
  assign out_strobe = out_valid_r;
  assign out_data   = out_r;

  // Commands beyond the store are dropped (write) or read as zero
  assign in_inside = (DW'(in_data.row) < MAXD) && (DW'(in_data.col) < MAXD);
  assign in_row_x  = RX'(in_data.row);
  assign in_col_x  = RX'(in_data.col);
  assign in_addr   = cell_addr(in_row_x[IW-1:0], in_col_x[IW-1:0]);

  // Saturate the dimensions in use to the store size
  assign nr = (DW'(grid_rows_r) > MAXD) ? MAXD : DW'(grid_rows_r);
  assign nc = (DW'(grid_cols_r) > MAXD) ? MAXD : DW'(grid_cols_r);

  assign has_interior = (nr >= DW'(3)) && (nc >= DW'(3));
  assign j_more       = (DW'(j_r) + DW'(2)) < nc;
  assign i_more       = (DW'(i_r) + DW'(2)) < nr;

  assign cnt_inc    = sweep_cnt_r + CNT_W'(1);
  assign keep_going = (largest_r > CHG_W'(tolerance_r)) && (cnt_inc < max_sweeps_r);

  assign rd_ext = {{(SUM_W - CELL_W){ram_rdata[CELL_W-1]}}, ram_rdata};
  // floor((sum + 2) / 4): acc holds sum + 2 after the round step
  assign nv     = acc_r[SUM_W-1:2];
  // In the abs step the adder holds the negated difference
  assign abs_chg = acc_r[SUM_W-1] ? alu_y[CHG_W-1:0] : acc_r[CHG_W-1:0];

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r  <= ROWS_RST;
      grid_cols_r  <= COLS_RST;
      tolerance_r  <= TOLERANCE_RST;
      max_sweeps_r <= MAX_SWEEPS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GRID_ROWS:  grid_rows_r  <= cfg_data[7:0];
        CFG_GRID_COLS:  grid_cols_r  <= cfg_data[7:0];
        CFG_TOLERANCE:  tolerance_r  <= cfg_data;
        CFG_MAX_SWEEPS: max_sweeps_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_data.operation)
            OP_SOLVE: state_nxt = S_SWEEP;
            OP_READ:  state_nxt = S_RDATA;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_RDATA: state_nxt = S_IDLE;
      S_SWEEP: state_nxt = has_interior ? S_FETCH : S_END;
      S_FETCH: state_nxt = (phase_r == PH_OLD) ? S_ROUND : S_FETCH;
      S_ROUND: state_nxt = S_DIFF;
      S_DIFF:  state_nxt = S_ABS;
      S_ABS:   state_nxt = (j_more || i_more) ? S_FETCH : S_END;
      S_END:   state_nxt = keep_going ? S_SWEEP : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: RAM port and shared adder control
  // --------------------------------------------------------------------------
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = in_addr;
    ram_wdata = in_data.value;
    alu_op    = ALU_ADD;
    alu_a     = acc_r;
    alu_b     = '0;
    unique case (state_r)
      S_IDLE: begin
        // Write lands at the accept edge; a read issues its address here too
        ram_we = accept && (in_data.operation == OP_WRITE) && in_inside;
      end
      S_FETCH: begin
        case (phase_r)
          PH_N:    ram_addr = cell_addr(i_r - IW'(1), j_r);
          PH_S:    ram_addr = cell_addr(i_r + IW'(1), j_r);
          PH_E:    ram_addr = cell_addr(i_r, j_r + IW'(1));
          PH_W:    ram_addr = cell_addr(i_r, j_r - IW'(1));
          default: ram_addr = cell_addr(i_r, j_r);
        endcase
        // First neighbor starts the sum from zero
        alu_a = (phase_r == PH_S) ? '0 : acc_r;
        alu_b = rd_ext;
      end
      S_ROUND: begin
        alu_b = SUM_W'(2);
      end
      S_DIFF: begin
        // Write back the new value, then form new minus old
        ram_we    = 1'b1;
        ram_addr  = cell_addr(i_r, j_r);
        ram_wdata = nv;
        alu_op    = ALU_SUB;
        alu_a     = SUM_W'(nv);
        alu_b     = SUM_W'(old_r);
      end
      S_ABS: begin
        alu_op = ALU_SUB;
        alu_a  = '0;
        alu_b  = acc_r;
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath and result register next values
  // --------------------------------------------------------------------------
  always_comb begin
    i_nxt         = i_r;
    j_nxt         = j_r;
    phase_nxt     = phase_r;
    acc_nxt       = acc_r;
    old_nxt       = old_r;
    largest_nxt   = largest_r;
    sweep_cnt_nxt = sweep_cnt_r;
    rd_inside_nxt = rd_inside_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          rd_inside_nxt = in_inside;
          unique case (in_data.operation)
            OP_SOLVE: sweep_cnt_nxt = '0;
            OP_READ:  ;
            default: begin
              out_valid_nxt = 1'b1;
              out_nxt       = '0;
            end
          endcase
        end
      end
      S_RDATA: begin
        out_valid_nxt      = 1'b1;
        out_nxt            = '0;
        out_nxt.read_value = rd_inside_r ? ram_rdata : '0;
      end
      S_SWEEP: begin
        largest_nxt = '0;
        i_nxt       = IW'(1);
        j_nxt       = IW'(1);
        phase_nxt   = PH_N;
      end
      S_FETCH: begin
        phase_nxt = phase_r + 3'd1;
        // Data lands one phase after its address
        case (phase_r) inside
          PH_S, PH_E, PH_W, PH_C: acc_nxt = alu_y;
          PH_OLD:                 old_nxt = ram_rdata;
          default: ;
        endcase
      end
      S_ROUND, S_DIFF: begin
        acc_nxt = alu_y;
      end
      S_ABS: begin
        if (abs_chg > largest_r) begin
          largest_nxt = abs_chg;
        end
        phase_nxt = PH_N;
        if (j_more) begin
          j_nxt = j_r + IW'(1);
        end else if (i_more) begin
          i_nxt = i_r + IW'(1);
          j_nxt = IW'(1);
        end
      end
      S_END: begin
        sweep_cnt_nxt = cnt_inc;
        if (!keep_going) begin
          out_valid_nxt       = 1'b1;
          out_nxt             = '0;
          out_nxt.sweeps_done = cnt_inc;
          out_nxt.converged   = (largest_r <= CHG_W'(tolerance_r));
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      i_r         <= '0;
      j_r         <= '0;
      phase_r     <= PH_N;
      largest_r   <= '0;
      sweep_cnt_r <= '0;
      rd_inside_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      phase_r     <= phase_nxt;
      largest_r   <= largest_nxt;
      sweep_cnt_r <= sweep_cnt_nxt;
      rd_inside_r <= rd_inside_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload: no reset needed
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    old_r <= old_nxt;
    out_r <= out_nxt;
  end

  // --------------------------------------------------------------------------
  // Grid store and shared adder
  // --------------------------------------------------------------------------
  gslps_ram #(
    .WIDTH (CELL_W),
    .DEPTH (DEPTH)
  ) u_grid_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  gslps_alu u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y)
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Every accepted command either answers next cycle or keeps the block busy
  `GSLPS_ASSERT_NXT(a_accept_progress, clk, rst_n, accept, out_valid_r || busy)
  // A converged solve always reports at least one sweep
  `GSLPS_ASSERT_IMP(a_conv_sweeps, clk, rst_n, out_valid_r && out_r.converged, out_r.sweeps_done != '0)
  // The store is never written while a cell's operands are being fetched
  `GSLPS_ASSERT_IMP(a_fetch_no_write, clk, rst_n, state_r == S_FETCH, !ram_we)

endmodule
